FILE: rtl/qdd_pkg.sv
// ----------------------------------------------------------------------------
// qdd_pkg
// Shared types and constants for the quadrature detent decoder: event codes,
// configuration register indexes, reset values and the Gray step table.
// ----------------------------------------------------------------------------
package qdd_pkg;

  typedef enum logic [1:0] {
    EV_NONE = 2'd0,
    EV_NEXT = 2'd1,
    EV_PREV = 2'd2
  } event_e;

  typedef enum logic [1:0] {
    CFG_STEPS_PER_DETENT  = 2'd0,
    CFG_MIN_GAP_MS        = 2'd1,
    CFG_REVERSE_DIRECTION = 2'd2
  } cfg_index_e;

  localparam int unsigned CfgIndexWidth = 2;
  localparam int unsigned CfgDataWidth  = 8;

  localparam logic [2:0] StepsPerDetentReset = 3'd4;
  localparam logic [7:0] MinGapMsReset       = 8'd5;
  localparam logic       ReverseReset        = 1'b0;

  typedef logic signed [3:0] accum_t;
  typedef logic signed [1:0] step_t;

  // index is {old pins, new pins}
  function automatic step_t gray_step(input logic [3:0] idx);
    step_t s;
    unique case (idx)
      4'd1, 4'd7, 4'd8, 4'd14: s = -2'sd1;
      4'd2, 4'd4, 4'd11, 4'd13: s = 2'sd1;
      default: s = 2'sd0;
    endcase
    return s;
  endfunction

endpackage

FILE: rtl/quadrature_detent_decoder.sv
// ----------------------------------------------------------------------------
// quadrature_detent_decoder
// Decodes sampled encoder phase pins into next/prev detent events with a
// minimum time gap between reported events.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one pin sample and the
//   current millisecond time. Output channel (out_valid_o / out_stall_i)
//   returns exactly one event code per accepted sample, in order.
//   An accepted sample's event goes to the result register, or, when that
//   register is full and not read, to a second slot that holds one more.
//   One sample can be accepted every cycle while that slot is empty; the
//   decoder state update, step table lookup, threshold compare and 32-bit
//   gap subtraction all sit in combinational logic in front of the result
//   register. in_stall_o rises only while the second slot is full, and
//   drops once the receiver takes a result.
//   Reset clears the decoder state (the first sample after reset primes it
//   and gives no event), empties both result slots and loads the register
//   defaults: 4 steps per detent, 5 ms gap, normal direction. Configuration
//   writes apply at the next edge; only the user ensures they come while idle.
// ----------------------------------------------------------------------------
module quadrature_detent_decoder (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [qdd_pkg::CfgIndexWidth-1:0]   cfg_index_i,
  input  logic [qdd_pkg::CfgDataWidth-1:0]    cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [1:0]                          phase_pins_i,
  input  logic [31:0]                         now_ms_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [1:0]                          event_res_o
);

  logic [2:0] steps_per_detent_q;
  logic [7:0] min_gap_ms_q;
  logic       reverse_q;

  logic              primed_q, primed_d;
  logic [1:0]        last_pins_q, last_pins_d;
  qdd_pkg::accum_t   accum_q, accum_d;
  logic [31:0]       last_time_q, last_time_d;

  logic              out_valid_q, out_valid_d;
  qdd_pkg::event_e   out_ev_q, out_ev_d;
  logic              skid_valid_q, skid_valid_d;
  qdd_pkg::event_e   skid_ev_q, skid_ev_d;

  logic              accept;
  logic              pop;
  qdd_pkg::event_e   new_ev;
  qdd_pkg::step_t    step;
  logic signed [4:0] sum;
  logic signed [4:0] limit;
  logic [31:0]       elapsed;
  logic              hit;
  logic              forward;

  assign accept     = in_valid_i && !skid_valid_q;
  assign pop        = out_valid_q && !out_stall_i;
  assign in_stall_o  = skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign event_res_o = out_ev_q;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      steps_per_detent_q <= qdd_pkg::StepsPerDetentReset;
      min_gap_ms_q       <= qdd_pkg::MinGapMsReset;
      reverse_q          <= qdd_pkg::ReverseReset;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        qdd_pkg::CFG_STEPS_PER_DETENT:  steps_per_detent_q <= cfg_data_i[2:0];
        qdd_pkg::CFG_MIN_GAP_MS:        min_gap_ms_q       <= cfg_data_i;
        qdd_pkg::CFG_REVERSE_DIRECTION: reverse_q          <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // decode
  always_comb begin
    step    = qdd_pkg::gray_step({last_pins_q, phase_pins_i});
    sum     = 5'(accum_q) + 5'(step);
    limit   = $signed({2'b00, steps_per_detent_q});
    hit     = (sum >= limit) || (sum <= -limit);
    forward = (sum > 5'sd0) ^ reverse_q;
    elapsed = now_ms_i - last_time_q;

    primed_d    = primed_q;
    last_pins_d = last_pins_q;
    accum_d     = accum_q;
    last_time_d = last_time_q;
    new_ev      = qdd_pkg::EV_NONE;

    if (!primed_q) begin
      primed_d    = 1'b1;
      last_pins_d = phase_pins_i;
      accum_d     = '0;
      last_time_d = '0;
    end else if (phase_pins_i != last_pins_q) begin
      last_pins_d = phase_pins_i;
      if (hit) begin
        accum_d = '0;
        if (elapsed >= {24'd0, min_gap_ms_q}) begin
          last_time_d = now_ms_i;
          new_ev      = forward ? qdd_pkg::EV_NEXT : qdd_pkg::EV_PREV;
        end
      end else begin
        accum_d = sum[3:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      primed_q    <= 1'b0;
      last_pins_q <= '0;
      accum_q     <= '0;
      last_time_q <= '0;
    end else if (accept) begin
      primed_q    <= primed_d;
      last_pins_q <= last_pins_d;
      accum_q     <= accum_d;
      last_time_q <= last_time_d;
    end
  end

  // result register and skid slot
  always_comb begin
    out_valid_d  = out_valid_q;
    out_ev_d     = out_ev_q;
    skid_valid_d = skid_valid_q;
    skid_ev_d    = skid_ev_q;
    if (accept) begin
      if (out_valid_q && !pop) begin
        skid_valid_d = 1'b1;
        skid_ev_d    = new_ev;
      end else begin
        out_valid_d = 1'b1;
        out_ev_d    = new_ev;
      end
    end else if (pop) begin
      out_valid_d  = skid_valid_q;
      out_ev_d     = skid_ev_q;
      skid_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_ev_q  <= out_ev_d;
    skid_ev_q <= skid_ev_d;
  end

endmodule
